// ===== hdl/hrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types and constants of the histogram range colorizer.
// ----------------------------------------------------------------------------
package hrc_pkg;

  localparam int CNT_W          = 11;  // iteration count field
  localparam int HIST_W         = 20;  // histogram entries and range totals
  localparam int BLUE_W         = 8;
  localparam int NUM_BOUND_REGS = 5;
  localparam int RNG_W          = 2;   // up to four ranges with five bounds
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 11;
  localparam int RC_W           = 3;

  localparam logic [1:0] FN_COUNT = 2'd0;
  localparam logic [1:0] FN_COLOR = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_LAST  = 3'd5;

  typedef struct packed {
    logic [1:0]       func;
    logic [CNT_W-1:0] iteration_count;
  } cmd_t;

  typedef struct packed {
    logic [BLUE_W-1:0] blue_level;
    logic              status;
  } pix_t;

  // Range of the current count and the bound where that range starts.
  typedef struct packed {
    logic [RNG_W-1:0] rng;
    logic [CNT_W-1:0] start;
  } lookup_t;

  typedef struct packed {
    logic              done;
    logic [BLUE_W-1:0] blue;
  } div_res_t;

  function automatic logic [HIST_W-1:0] sat_inc(input logic [HIST_W-1:0] v);
    sat_inc = (v == {HIST_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== hdl/histogram_range_colorizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_range_colorizer
// Histogram-equalized blue level of escape-time counts, per iteration range.
// ----------------------------------------------------------------------------
//  channel | signals                          | dir | content
//  cmd     | cmd_valid, cmd_stall, cmd        | in  | func, iteration_count
//  pix     | pix_valid, pix_stall, pix        | out | blue_level, status
//  cfg     | cfg_wen, cfg_index, cfg_data     | in  | range_count, bounds
//
// One item at a time. A count item reads the histogram entry, then writes it
// back. A color item walks the histogram RAM read port, one entry per cycle,
// from the range start to the count, then runs the eight-step divider, which
// skips its steps when the level saturates; with no walk due, both are skipped.
// A clear item and reset both start a sweep that writes MAX_ITERS zeros, one
// per cycle, while cmd_stall stays high.
// A waiting result sits in the pix register; the next color item then holds
// its result, and cmd_stall, until the pix register frees up.
// ----------------------------------------------------------------------------
module histogram_range_colorizer
  import hrc_pkg::*;
#(
  parameter int MAX_ITERS  = 1024,
  parameter int MAX_BOUNDS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd,
  output logic                  pix_valid,
  input  logic                  pix_stall,
  output pix_t                  pix,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = $clog2(MAX_ITERS);
  localparam int PTR_W  = CNT_W + 1;
  localparam int EXT_W  = (AW > PTR_W) ? AW : PTR_W;
  localparam int SUM_W  = HIST_W + AW;
  localparam int NB_EFF = (MAX_BOUNDS < NUM_BOUND_REGS) ? MAX_BOUNDS : NUM_BOUND_REGS;
  localparam int NR     = NB_EFF - 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CNT, S_LOOK, S_SUM, S_DIV, S_OUT
  } state_t;

  state_t            state;
  cmd_t              item;
  logic [AW-1:0]     clr_addr;
  logic [PTR_W-1:0]  ptr;
  logic              rd_pend;
  logic [SUM_W-1:0]  sum;
  logic [HIST_W-1:0] total;
  logic [BLUE_W-1:0] blue;
  logic              status;
  logic [HIST_W-1:0] totals [NR];

  lookup_t           lk;
  div_res_t          dres;
  logic              accept;
  logic              cmd_in_range;
  logic              item_in_range;
  logic              more;
  logic              div_start;
  logic [EXT_W-1:0]  cmd_ext;
  logic [EXT_W-1:0]  item_ext;
  logic [EXT_W-1:0]  ptr_ext;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [HIST_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [HIST_W-1:0] ram_rdata;

  assign cmd_stall     = (state != S_IDLE);
  assign accept        = cmd_valid && !cmd_stall;
  assign cmd_in_range  = (32'(cmd.iteration_count) < MAX_ITERS);
  assign item_in_range = (32'(item.iteration_count) < MAX_ITERS);
  assign cmd_ext       = EXT_W'(cmd.iteration_count);
  assign item_ext      = EXT_W'(item.iteration_count);
  assign ptr_ext       = EXT_W'(ptr);
  assign more          = (ptr <= PTR_W'(item.iteration_count));
  assign div_start     = (state == S_SUM) && !more && !rd_pend;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = item_ext[AW-1:0];
    ram_wdata = sat_inc(ram_rdata);
    ram_re    = 1'b0;
    ram_raddr = ptr_ext[AW-1:0];
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_re    = accept && cmd.func == FN_COUNT && cmd_in_range;
        ram_raddr = cmd_ext[AW-1:0];
      end
      S_CNT: begin
        ram_we = 1'b1;
      end
      S_SUM: begin
        ram_re = more;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  hrc_ram #(
    .WIDTH (HIST_W),
    .DEPTH (MAX_ITERS)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hrc_cfg #(
    .MAX_BOUNDS (MAX_BOUNDS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .count     (item.iteration_count),
    .lk        (lk)
  );

  hrc_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (sum),
    .total (total),
    .res   (dres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      pix_valid <= 1'b0;
      for (int i = 0; i < NR; i++) begin
        totals[i] <= '0;
      end
    end else begin
      // In the result phase the load below decides pix_valid.
      if (pix_valid && !pix_stall && state != S_OUT) begin
        pix_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAX_ITERS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item <= cmd;
            case (cmd.func)
              FN_COUNT: begin
                if (cmd_in_range) begin
                  state <= S_CNT;
                end
              end
              FN_COLOR: state <= S_LOOK;
              FN_CLEAR: begin
                for (int i = 0; i < NR; i++) begin
                  totals[i] <= '0;
                end
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CNT: begin
          // The histogram entry is written back by the RAM port this cycle.
          totals[lk.rng] <= sat_inc(totals[lk.rng]);
          state          <= S_IDLE;
        end
        S_LOOK: begin
          blue   <= '0;
          status <= 1'b0;
          total  <= totals[lk.rng];
          ptr    <= PTR_W'(lk.start);
          sum    <= '0;
          rd_pend <= 1'b0;
          if (!item_in_range) begin
            state <= S_OUT;
          end else if (totals[lk.rng] == '0) begin
            status <= 1'b1;
            state  <= S_OUT;
          end else if (lk.start > item.iteration_count) begin
            state <= S_OUT;
          end else begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          rd_pend <= more;
          if (more) begin
            ptr <= ptr + 1'b1;
          end
          if (rd_pend) begin
            sum <= sum + SUM_W'(ram_rdata);
          end
          if (div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dres.done) begin
            blue  <= dres.blue;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!pix_valid || !pix_stall) begin
            pix.blue_level <= blue;
            pix.status     <= status;
            pix_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SUM |-> ptr <= PTR_W'(item.iteration_count) + 1'b1)
    else $error("histogram walk pointer ran past the count");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    dres.done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_rng_legal: assert property (@(posedge clk) disable iff (rst)
    state == S_CNT |-> 32'(lk.rng) < NR)
    else $error("range index beyond the range totals");

  a_clear_start: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.func == FN_CLEAR |=> state == S_CLEAR && clr_addr == '0)
    else $error("clear item did not start the sweep at entry zero");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(pix_valid) |-> $past(state) == S_OUT)
    else $error("result loaded outside the result phase");
`endif

endmodule

// ===== hdl/hrc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hrc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/hrc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_cfg
// Configuration registers and the range lookup for an iteration count.
// ----------------------------------------------------------------------------
module hrc_cfg
  import hrc_pkg::*;
#(
  parameter int MAX_BOUNDS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CNT_W-1:0]      count,
  output lookup_t               lk
);

  localparam int NB_EFF = (MAX_BOUNDS < NUM_BOUND_REGS) ? MAX_BOUNDS : NUM_BOUND_REGS;

  logic [RC_W-1:0]  range_count;
  logic [CNT_W-1:0] bounds [NUM_BOUND_REGS];
  logic [CFG_IDX_W-1:0] bound_sel;

  assign bound_sel = cfg_index - REG_BOUND_FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= RC_W'(2);
      bounds[0]   <= '0;
      for (int i = 1; i < NUM_BOUND_REGS; i++) begin
        bounds[i] <= CNT_W'(1024);
      end
    end else if (cfg_wen) begin
      if (cfg_index == REG_RANGE_COUNT) begin
        range_count <= cfg_data[RC_W-1:0];
      end else if (cfg_index >= REG_BOUND_FIRST && cfg_index <= REG_BOUND_LAST) begin
        bounds[bound_sel] <= cfg_data[CNT_W-1:0];
      end
    end
  end

  // The range is the first bound above the count, less one; past the last
  // bound in use the count belongs to the last range.
  always_comb begin
    logic [RC_W-1:0]  n;
    logic             found;
    logic [RNG_W-1:0] rng;
    n = (range_count < RC_W'(2)) ? RC_W'(2) : range_count;
    if (n > RC_W'(NB_EFF)) n = RC_W'(NB_EFF);
    found = 1'b0;
    rng   = RNG_W'(n - RC_W'(2));
    for (int i = 1; i < NUM_BOUND_REGS; i++) begin
      if (!found && RC_W'(i) < n && bounds[i] > count) begin
        rng   = RNG_W'(i - 1);
        found = 1'b1;
      end
    end
    lk.rng   = rng;
    lk.start = bounds[{1'b0, rng}];
  end

endmodule

// ===== hdl/hrc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_div
// Scaling unit: floor(255 * sum / total), saturated at 255, by an eight-step
// restoring division after a saturation check.
// ----------------------------------------------------------------------------
module hrc_div
  import hrc_pkg::*;
#(
  parameter int SUM_W = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  sum,
  input  logic [HIST_W-1:0] total,
  output div_res_t          res
);

  localparam int SC_W = SUM_W + BLUE_W;
  localparam int DV_W = HIST_W + BLUE_W;

  typedef enum logic [1:0] {D_IDLE, D_SCALE, D_SAT, D_STEP} dstate_t;

  dstate_t           state;
  logic [SUM_W-1:0]  sum_q;
  logic [HIST_W-1:0] total_q;
  logic [SC_W-1:0]   scaled;
  logic [DV_W-1:0]   rem;
  logic [DV_W-1:0]   dvs;
  logic [BLUE_W-1:0] quo;
  logic [2:0]        step;
  logic              ge;
  logic              sat;

  assign ge  = (rem >= dvs);
  assign sat = (scaled >= SC_W'({total_q, {BLUE_W{1'b0}}}));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= ((state == D_SAT) && sat) || ((state == D_STEP) && (step == 3'd0));
      case (state)
        D_IDLE: begin
          if (start) begin
            sum_q   <= sum;
            total_q <= total;
            state   <= D_SCALE;
          end
        end
        D_SCALE: begin
          scaled <= {sum_q, {BLUE_W{1'b0}}} - SC_W'(sum_q);
          state  <= D_SAT;
        end
        D_SAT: begin
          if (sat) begin
            res.blue <= {BLUE_W{1'b1}};
            state    <= D_IDLE;
          end else begin
            // Below 256 * total, so the remainder fits the divisor width.
            rem   <= scaled[DV_W-1:0];
            dvs   <= {1'b0, total_q, {(BLUE_W-1){1'b0}}};
            step  <= 3'd7;
            state <= D_STEP;
          end
        end
        D_STEP: begin
          if (ge) begin
            rem <= rem - dvs;
          end
          quo <= {quo[BLUE_W-2:0], ge};
          dvs <= dvs >> 1;
          if (step == 3'd0) begin
            res.blue <= {quo[BLUE_W-2:0], ge};
            state    <= D_IDLE;
          end else begin
            step <= step - 3'd1;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule
